>>> rtl/core/thl_pkg.sv
// ----------------------------------------------------------------------------
// thl_pkg: shared types and constants for the transition histogram ledger
// Field widths, opcodes, read-address selects and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package thl_pkg;

   localparam int NUM_TYPES  = 256;
   localparam int NUM_ACTORS = 16;
   localparam int COUNT_W    = 48;
   localparam int TYPE_W     = $clog2(NUM_TYPES);
   localparam int ACTOR_W    = $clog2(NUM_ACTORS);
   localparam int AMT_W      = 32;
   localparam int OPC_W      = 2;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 4 * COUNT_W;

   localparam logic [COUNT_W-1:0] CNT_SMAX = {1'b0, {(COUNT_W-1){1'b1}}};
   localparam logic [COUNT_W-1:0] CNT_SMIN = {1'b1, {(COUNT_W-1){1'b0}}};
   localparam logic [COUNT_W-1:0] CNT_UMAX = {COUNT_W{1'b1}};

   localparam logic [OPC_W-1:0] OP_RECORD     = 2'd0;
   localparam logic [OPC_W-1:0] OP_QUERY_TYPE = 2'd1;
   localparam logic [OPC_W-1:0] OP_QUERY_ACTR = 2'd2;
   localparam logic [OPC_W-1:0] OP_CLEAR      = 2'd3;

   localparam logic [1:0] RD_FROM  = 2'd0;
   localparam logic [1:0] RD_TO    = 2'd1;
   localparam logic [1:0] RD_QUERY = 2'd2;

   typedef struct packed {
      logic       ld_item;
      logic [1:0] rd_sel;
      logic       wr_from;
      logic       wr_to;
      logic       upd_counts;
      logic       cap_total;
      logic       clr_all;
      logic       ld_rsp;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } sts_type;

endpackage

>>> rtl/core/thl_ram.sv
// ----------------------------------------------------------------------------
// thl_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module thl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/thl_ctrl.sv
// ----------------------------------------------------------------------------
// thl_ctrl: sequencing state machine
// Walks each item through its read-modify-write, query or clear steps and issues
// commands to the datapath.
// ----------------------------------------------------------------------------
module thl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [thl_pkg::OPC_W-1:0] req_opcode,
   input  thl_pkg::sts_type        sts,
   output thl_pkg::cmd_type        cmd
);
   import thl_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_RD_FROM  = 4'd1;
   localparam logic [3:0] ST_WR_FROM  = 4'd2;
   localparam logic [3:0] ST_RD_TO    = 4'd3;
   localparam logic [3:0] ST_WR_TO    = 4'd4;
   localparam logic [3:0] ST_QRY_RD   = 4'd5;
   localparam logic [3:0] ST_QRY_CAP  = 4'd6;
   localparam logic [3:0] ST_CLEAR    = 4'd7;
   localparam logic [3:0] ST_DONE     = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_FROM;
      case (state_ff)
         ST_IDLE: begin
            cmd.ld_item = accept;
            if (accept) begin
               case (req_opcode)
                  OP_RECORD:     state_in = ST_RD_FROM;
                  OP_QUERY_TYPE: state_in = ST_QRY_RD;
                  OP_QUERY_ACTR: state_in = ST_DONE;
                  default:       state_in = ST_CLEAR;
               endcase
            end
         end
         ST_RD_FROM: state_in = ST_WR_FROM;
         ST_WR_FROM: begin
            cmd.wr_from = 1'b1;
            state_in    = ST_RD_TO;
         end
         ST_RD_TO: begin
            cmd.rd_sel = RD_TO;
            state_in   = ST_WR_TO;
         end
         ST_WR_TO: begin
            cmd.rd_sel     = RD_TO;
            cmd.wr_to      = 1'b1;
            cmd.upd_counts = 1'b1;
            state_in       = ST_DONE;
         end
         ST_QRY_RD: begin
            cmd.rd_sel = RD_QUERY;
            state_in   = ST_QRY_CAP;
         end
         ST_QRY_CAP: begin
            cmd.rd_sel    = RD_QUERY;
            cmd.cap_total = 1'b1;
            state_in      = ST_DONE;
         end
         ST_CLEAR: begin
            cmd.clr_all = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to drain
            if (sts.rsp_free) begin
               cmd.ld_rsp = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted item did not start a sequence");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !sts.rsp_free) |=> state_ff == ST_DONE)
      else $error("left done state while output register full");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_from, cmd.wr_to, cmd.cap_total, cmd.clr_all, cmd.ld_rsp,
                cmd.ld_item}))
      else $error("conflicting datapath commands");

endmodule

>>> rtl/core/thl_dpath.sv
// ----------------------------------------------------------------------------
// thl_dpath: counter storage and arithmetic
// Type count RAM with valid bits, per-actor counters, running change total,
// saturating add/subtract and the output register.
// ----------------------------------------------------------------------------
module thl_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  thl_pkg::cmd_type             cmd,
   output thl_pkg::sts_type             sts,
   input  logic                         csr_we,
   input  logic [thl_pkg::TYPE_W-1:0]   csr_wdata,
   input  logic [thl_pkg::OPC_W-1:0]    in_opcode,
   input  logic [thl_pkg::TYPE_W-1:0]   in_from_type,
   input  logic [thl_pkg::TYPE_W-1:0]   in_to_type,
   input  logic [thl_pkg::AMT_W-1:0]    in_change_amount,
   input  logic                         in_is_player_action,
   input  logic [thl_pkg::ACTOR_W-1:0]  in_actor_id,
   input  logic [thl_pkg::TYPE_W-1:0]   in_query_type,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [thl_pkg::COUNT_W-1:0]  rsp_type_total,
   output logic [thl_pkg::COUNT_W-1:0]  rsp_placed_count,
   output logic [thl_pkg::COUNT_W-1:0]  rsp_removed_count,
   output logic [thl_pkg::COUNT_W-1:0]  rsp_change_total
);
   import thl_pkg::*;

   logic [TYPE_W-1:0]  empty_type_ff;
   logic [OPC_W-1:0]   opcode_ff;
   logic [TYPE_W-1:0]  from_ff, to_ff, qtype_ff;
   logic [AMT_W-1:0]   amount_ff;
   logic               player_ff;
   logic [ACTOR_W-1:0] actor_ff;

   logic [NUM_TYPES-1:0]  type_valid_ff;
   logic [COUNT_W-1:0]    placed_ff  [NUM_ACTORS];
   logic [COUNT_W-1:0]    removed_ff [NUM_ACTORS];
   logic [NUM_ACTORS-1:0] actor_valid_ff;
   logic [COUNT_W-1:0]    changes_ff;
   logic [COUNT_W-1:0]    total_hold_ff;

   logic                  rsp_valid_ff;
   logic [COUNT_W-1:0]    rsp_total_ff, rsp_placed_ff, rsp_removed_ff, rsp_change_ff;

   logic [TYPE_W-1:0]  rd_addr, rd_addr_ff;
   logic [COUNT_W-1:0] rd_data, type_val;
   logic               active, from_cnt, to_cnt;
   logic [COUNT_W:0]   diff, sum, pl_sum, rm_sum, ch_sum;
   logic [COUNT_W-1:0] sub_val, add_val;
   logic               ram_we;
   logic [TYPE_W-1:0]  ram_waddr;
   logic [COUNT_W-1:0] ram_wdata;
   logic [COUNT_W-1:0] pl_base, rm_base;
   logic               credit;
   logic [COUNT_W:0]   amt_ext;

   assign active   = (from_ff != to_ff) && (amount_ff != '0);
   assign from_cnt = (from_ff != empty_type_ff);
   assign to_cnt   = (to_ff != empty_type_ff);
   assign amt_ext  = {{(COUNT_W+1-AMT_W){1'b0}}, amount_ff};

   always_comb begin
      case (cmd.rd_sel)
         RD_FROM:  rd_addr = from_ff;
         RD_TO:    rd_addr = to_ff;
         RD_QUERY: rd_addr = qtype_ff;
         default:  rd_addr = from_ff;
      endcase
   end

   thl_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_TYPES)) u_type_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // an entry without its valid bit reads as zero
   assign type_val = type_valid_ff[rd_addr_ff] ? rd_data : '0;

   // signed saturation: overflow shows as a mismatch of the two top bits
   assign diff    = {type_val[COUNT_W-1], type_val} - amt_ext;
   assign sum     = {type_val[COUNT_W-1], type_val} + amt_ext;
   assign sub_val = (diff[COUNT_W] != diff[COUNT_W-1]) ? CNT_SMIN : diff[COUNT_W-1:0];
   assign add_val = (sum[COUNT_W] != sum[COUNT_W-1]) ? CNT_SMAX : sum[COUNT_W-1:0];

   assign ram_we    = active && ((cmd.wr_from && from_cnt) || (cmd.wr_to && to_cnt));
   assign ram_waddr = cmd.wr_to ? to_ff : from_ff;
   assign ram_wdata = cmd.wr_to ? add_val : sub_val;

   assign credit  = cmd.upd_counts && active && player_ff;
   assign pl_base = actor_valid_ff[actor_ff] ? placed_ff[actor_ff] : '0;
   assign rm_base = actor_valid_ff[actor_ff] ? removed_ff[actor_ff] : '0;
   assign pl_sum  = {1'b0, pl_base} + amt_ext;
   assign rm_sum  = {1'b0, rm_base} + amt_ext;
   assign ch_sum  = {1'b0, changes_ff} + amt_ext;

   always_ff @(posedge clock) begin
      if (cmd.ld_item) begin
         opcode_ff <= in_opcode;
         from_ff   <= in_from_type;
         to_ff     <= in_to_type;
         amount_ff <= in_change_amount;
         player_ff <= in_is_player_action;
         actor_ff  <= in_actor_id;
         qtype_ff  <= in_query_type;
      end
      rd_addr_ff <= rd_addr;
      if (cmd.cap_total) begin
         total_hold_ff <= type_val;
      end
      if (credit) begin
         if (to_cnt) begin
            placed_ff[actor_ff] <= pl_sum[COUNT_W] ? CNT_UMAX : pl_sum[COUNT_W-1:0];
         end else begin
            placed_ff[actor_ff] <= pl_base;
         end
         if (from_cnt) begin
            removed_ff[actor_ff] <= rm_sum[COUNT_W] ? CNT_UMAX : rm_sum[COUNT_W-1:0];
         end else begin
            removed_ff[actor_ff] <= rm_base;
         end
      end
      if (cmd.ld_rsp) begin
         rsp_total_ff   <= (opcode_ff == OP_QUERY_TYPE) ? total_hold_ff : '0;
         rsp_placed_ff  <= (opcode_ff == OP_QUERY_ACTR && actor_valid_ff[actor_ff])
                           ? placed_ff[actor_ff] : '0;
         rsp_removed_ff <= (opcode_ff == OP_QUERY_ACTR && actor_valid_ff[actor_ff])
                           ? removed_ff[actor_ff] : '0;
         rsp_change_ff  <= changes_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_type_ff  <= '0;
         type_valid_ff  <= '0;
         actor_valid_ff <= '0;
         changes_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            empty_type_ff <= csr_wdata;
         end
         if (cmd.clr_all) begin
            type_valid_ff  <= '0;
            actor_valid_ff <= '0;
            changes_ff     <= '0;
         end else begin
            if (ram_we) begin
               type_valid_ff[ram_waddr] <= (ram_wdata != '0);
            end
            if (credit) begin
               actor_valid_ff[actor_ff] <= 1'b1;
            end
            if (cmd.upd_counts && active) begin
               changes_ff <= ch_sum[COUNT_W] ? CNT_UMAX : ch_sum[COUNT_W-1:0];
            end
         end
         if (cmd.ld_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.rsp_free      = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_type_total    = rsp_total_ff;
   assign rsp_placed_count  = rsp_placed_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_change_total  = rsp_change_ff;

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_all |=> (changes_ff == '0 && type_valid_ff == '0 && actor_valid_ff == '0))
      else $error("clear left state behind");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_rsp |-> sts.rsp_free)
      else $error("output register overwritten before it was taken");

   a_zero_invalidates: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_wdata == '0 && !cmd.clr_all) |=> !type_valid_ff[$past(ram_waddr)])
      else $error("zero count left its valid bit set");

endmodule

>>> rtl/core/transition_histogram_ledger_core.sv
// One item at a time. A record reads and writes the from entry, then the to
// entry; a type query reads and captures the type's count; a clear resets the
// valid bits and change total; an actor query goes straight to the done step.
// The next item is accepted the cycle after the result is loaded; a waiting
// result holds the done step and the input. A record makes two read-modify-writes through one RAM read port.
// Reset: synchronous, clears all counters (valid bits), empty_type and output valid.
// ----------------------------------------------------------------------------
// transition_histogram_ledger_core: type histogram and actor counter ledger
// Stream in requests, stream out one result per request; one config register.
// ----------------------------------------------------------------------------
module transition_histogram_ledger_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [thl_pkg::TYPE_W-1:0]        csr_wdata,    // empty_type
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // from_type[7:0], to_type[15:8], change_amount[47:16], is_player_action[48],
   // actor_id[52:49], query_type[60:53], zero[63:61]
   input  logic [thl_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [thl_pkg::OPC_W-1:0]         req_tuser,    // opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // type_total[47:0], placed_count[95:48], removed_count[143:96],
   // change_total[191:144]
   output logic [thl_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import thl_pkg::*;

   cmd_type            cmd;
   sts_type            sts;
   logic [COUNT_W-1:0] total, placed, removed, change;

   thl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   thl_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .in_opcode           (req_tuser),
      .in_from_type        (req_tdata[7:0]),
      .in_to_type          (req_tdata[15:8]),
      .in_change_amount    (req_tdata[47:16]),
      .in_is_player_action (req_tdata[48]),
      .in_actor_id         (req_tdata[52:49]),
      .in_query_type       (req_tdata[60:53]),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_type_total      (total),
      .rsp_placed_count    (placed),
      .rsp_removed_count   (removed),
      .rsp_change_total    (change)
   );

   assign rsp_tdata = {change, removed, placed, total};

endmodule
